// ===== rtl/cobs_stream_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// COBS stream deframer assertion macros
// Shared concurrent assertion forms on clock with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef COBS_STREAM_DEFRAMER_MACROS_SVH
`define COBS_STREAM_DEFRAMER_MACROS_SVH

// same-cycle implication
`define COBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define COBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cobs_pkg.sv =====
// ----------------------------------------------------------------------------
// COBS deframer package
// Shared types and constants of the COBS stream deframer.
// ----------------------------------------------------------------------------
package cobs_pkg;

   localparam logic [7:0] LONG_CODE = 8'hFF;
   localparam logic [7:0] DELIMITER = 8'h00;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_MALFORMED = 2'd2
   } cobs_status_type;

   typedef struct packed {
      logic [7:0]      out_byte;
      logic            end_of_frame;
      cobs_status_type frame_status;
      logic [8:0]      frame_length;
      logic [31:0]     bad_frame_total;
   } cobs_result_type;

endpackage

// ===== rtl/cobs_in_stage.sv =====
// ----------------------------------------------------------------------------
// COBS input stage
// Registers one link byte per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module cobs_in_stage import cobs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_link_byte,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       load;

   assign load      = !valid_ff || advance;
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_link_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== rtl/cobs_dec_core.sv =====
// ----------------------------------------------------------------------------
// COBS decoder core
// Frame state and combinational decode of one link byte into at most one result.
// ----------------------------------------------------------------------------
module cobs_dec_core import cobs_pkg::*; #(
   parameter int RAW_MAX     = 256,
   parameter int DECODED_MAX = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic [7:0]      item_byte,
   output logic            res_valid,
   output cobs_result_type res
);

   localparam int RAW_W = $clog2(RAW_MAX + 1);
   localparam int DEC_W = $clog2(DECODED_MAX + 1);

   logic [RAW_W-1:0] raw_count_ff, raw_count_in;
   logic             raw_overflow_ff, raw_overflow_in;
   logic [7:0]       run_left_ff, run_left_in;
   logic             long_block_ff, long_block_in;
   logic             zero_pending_ff, zero_pending_in;
   logic [DEC_W-1:0] decoded_count_ff, decoded_count_in;
   logic             length_error_ff, length_error_in;
   logic [31:0]      bad_frames_ff, bad_frames_in;

   logic             emit_req;
   logic [7:0]       emit_value;
   logic [7:0]       run_next;
   cobs_status_type  status;

   always_comb begin
      raw_count_in     = raw_count_ff;
      raw_overflow_in  = raw_overflow_ff;
      run_left_in      = run_left_ff;
      long_block_in    = long_block_ff;
      zero_pending_in  = zero_pending_ff;
      decoded_count_in = decoded_count_ff;
      length_error_in  = length_error_ff;
      bad_frames_in    = bad_frames_ff;
      emit_req         = 1'b0;
      emit_value       = item_byte;
      run_next         = run_left_ff - 8'd1;
      res_valid        = 1'b0;
      res              = '0;

      if (raw_overflow_ff) begin
         status = STATUS_OVERFLOW;
      end else if (length_error_ff || (run_left_ff != 8'd0)) begin
         status = STATUS_MALFORMED;
      end else begin
         status = STATUS_GOOD;
      end

      if (fire) begin
         if (item_byte == DELIMITER) begin
            if (raw_overflow_ff || (raw_count_ff != '0)) begin
               if (status != STATUS_GOOD) begin
                  bad_frames_in = bad_frames_ff + 32'd1;
               end
               res_valid           = 1'b1;
               res.end_of_frame    = 1'b1;
               res.frame_status    = status;
               res.frame_length    = 9'(decoded_count_ff);
               res.bad_frame_total = bad_frames_in;
            end
            raw_count_in     = '0;
            raw_overflow_in  = 1'b0;
            run_left_in      = 8'd0;
            long_block_in    = 1'b0;
            zero_pending_in  = 1'b0;
            decoded_count_in = '0;
            length_error_in  = 1'b0;
         end else if (!raw_overflow_ff) begin
            if (raw_count_ff == RAW_W'(RAW_MAX)) begin
               raw_overflow_in = 1'b1;
            end else begin
               raw_count_in = raw_count_ff + RAW_W'(1);
               if (run_left_ff == 8'd0) begin
                  emit_req        = zero_pending_ff;
                  emit_value      = 8'd0;
                  long_block_in   = (item_byte == LONG_CODE);
                  run_left_in     = item_byte - 8'd1;
                  zero_pending_in = (item_byte == 8'd1);
               end else begin
                  emit_req        = 1'b1;
                  run_left_in     = run_next;
                  zero_pending_in = (run_next == 8'd0) && !long_block_ff;
               end
            end
         end
      end

      if (emit_req && !length_error_ff) begin
         if (decoded_count_ff == DEC_W'(DECODED_MAX)) begin
            length_error_in = 1'b1;
         end else begin
            decoded_count_in = decoded_count_ff + DEC_W'(1);
            res_valid        = 1'b1;
            res.out_byte     = emit_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff     <= '0;
         raw_overflow_ff  <= 1'b0;
         run_left_ff      <= 8'd0;
         long_block_ff    <= 1'b0;
         zero_pending_ff  <= 1'b0;
         decoded_count_ff <= '0;
         length_error_ff  <= 1'b0;
         bad_frames_ff    <= 32'd0;
      end else begin
         raw_count_ff     <= raw_count_in;
         raw_overflow_ff  <= raw_overflow_in;
         run_left_ff      <= run_left_in;
         long_block_ff    <= long_block_in;
         zero_pending_ff  <= zero_pending_in;
         decoded_count_ff <= decoded_count_in;
         length_error_ff  <= length_error_in;
         bad_frames_ff    <= bad_frames_in;
      end
   end

endmodule

// ===== rtl/cobs_out_stage.sv =====
// ----------------------------------------------------------------------------
// COBS output stage
// Result register; holds a result until the consumer takes the transfer.
// ----------------------------------------------------------------------------
module cobs_out_stage import cobs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  cobs_result_type res,
   output logic            out_free,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cobs_result_type rsp_res
);

   logic            valid_ff;
   logic            valid_in;
   cobs_result_type res_ff;
   cobs_result_type res_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

// ===== rtl/cobs_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// COBS stream deframer
// Decodes a COBS-framed serial byte stream into data bytes and frame-end status.
// ----------------------------------------------------------------------------
// One link byte is taken per cycle, every cycle, when the result side keeps
// up; a transfer on req_ passes the input register and then the result
// register before its result shows on rsp_. The decoder core between them
// updates all frame state combinationally for each byte. Decoded
// bytes leave before the frame is checked: drop every byte of a frame whose
// end-of-frame result carries a status other than good. Empty frames give no
// result. A byte that gives no result is still taken at the full rate.
`include "cobs_stream_deframer_macros.svh"

module cobs_stream_deframer import cobs_pkg::*; #(
   parameter int RAW_MAX     = 256,
   parameter int DECODED_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_link_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_frame,
   output logic [1:0]  rsp_frame_status,
   output logic [8:0]  rsp_frame_length,
   output logic [31:0] rsp_bad_frame_total
);

   logic            item_valid;
   logic [7:0]      item_byte;
   logic            out_free;
   logic            fire;
   logic            res_valid;
   cobs_result_type res;
   cobs_result_type rsp_res;
   logic            data_fields_zero;

   assign fire = item_valid && out_free;

   cobs_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_link_byte (req_link_byte),
      .advance       (fire),
      .item_valid    (item_valid),
      .item_byte     (item_byte)
   );

   cobs_dec_core #(
      .RAW_MAX     (RAW_MAX),
      .DECODED_MAX (DECODED_MAX)
   ) u_dec_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item_byte (item_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   cobs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_byte        = rsp_res.out_byte;
   assign rsp_end_of_frame    = rsp_res.end_of_frame;
   assign rsp_frame_status    = rsp_res.frame_status;
   assign rsp_frame_length    = rsp_res.frame_length;
   assign rsp_bad_frame_total = rsp_res.bad_frame_total;

   assign data_fields_zero = (rsp_frame_status == STATUS_GOOD) &&
                             (rsp_frame_length == 9'd0) &&
                             (rsp_bad_frame_total == 32'd0);

   `COBS_ASSERT_NOW(a_stall_needs_item, req_stall, item_valid, "stall without held byte")
   `COBS_ASSERT_NOW(a_full_rate, item_valid && !rsp_stall, !req_stall, "stall while drained")
   `COBS_ASSERT_NEXT(a_result_from_fire, !rsp_valid && !fire, !rsp_valid, "result without fire")
   `COBS_ASSERT_NOW(a_data_fields_clear, rsp_valid && !rsp_end_of_frame, data_fields_zero, "data result with status")

endmodule

// ===== bench/cobs_decode_monitor.sv =====
// ----------------------------------------------------------------------------
// COBS decode monitor
// Watches both channels of the COBS stream deframer. It decodes each accepted
// link byte with its own copy of the frame state to get the data bytes and
// frame-end status the block should return. It compares every returned result,
// field by field, with the oldest one still owed, and counts the mismatches.
// ----------------------------------------------------------------------------
module cobs_decode_monitor import cobs_pkg::*; #(
   parameter int RAW_MAX     = 256,
   parameter int DECODED_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_link_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_end_of_frame,
   input  logic [1:0]  rsp_frame_status,
   input  logic [8:0]  rsp_frame_length,
   input  logic [31:0] rsp_bad_frame_total,
   output int          mismatch_count,
   output int          results_owed
);

   cobs_result_type owed_q[$];

   int unsigned frame_raw_bytes;
   bit          frame_overrun;
   logic [7:0]  bytes_owed;
   bit          in_long_run;
   bit          zero_owed;
   int unsigned frame_decoded;
   bit          frame_too_long;
   logic [31:0] bad_frame_tally;

   function automatic bit take_decoded();
      if (frame_too_long)
         return 1'b0;
      if (frame_decoded >= DECODED_MAX) begin
         frame_too_long = 1'b1;
         return 1'b0;
      end
      frame_decoded++;
      return 1'b1;
   endfunction

   task automatic decode_link_byte(input logic [7:0] link);
      cobs_result_type res;
      bit produced;
      res = '0;
      produced = 1'b0;
      if (link == DELIMITER) begin
         if (frame_overrun || frame_raw_bytes != 0) begin
            res.end_of_frame = 1'b1;
            if (frame_overrun)
               res.frame_status = STATUS_OVERFLOW;
            else if (frame_too_long || bytes_owed != 0)
               res.frame_status = STATUS_MALFORMED;
            else
               res.frame_status = STATUS_GOOD;
            if (res.frame_status != STATUS_GOOD)
               bad_frame_tally++;
            res.frame_length    = 9'(frame_decoded);
            res.bad_frame_total = bad_frame_tally;
            produced = 1'b1;
         end
         frame_raw_bytes = 0;
         frame_overrun   = 1'b0;
         bytes_owed      = '0;
         in_long_run     = 1'b0;
         zero_owed       = 1'b0;
         frame_decoded   = 0;
         frame_too_long  = 1'b0;
      end else if (!frame_overrun) begin
         if (frame_raw_bytes >= RAW_MAX) begin
            frame_overrun = 1'b1;
         end else begin
            frame_raw_bytes++;
            if (bytes_owed == 0) begin
               if (zero_owed)
                  produced = take_decoded();
               zero_owed   = 1'b0;
               in_long_run = (link == LONG_CODE);
               bytes_owed  = link - 8'd1;
            end else begin
               produced    = take_decoded();
               res.out_byte = link;
               bytes_owed--;
            end
            if (bytes_owed == 0 && !in_long_run)
               zero_owed = 1'b1;
         end
      end
      if (produced)
         owed_q.push_back(res);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      cobs_result_type want;
      if (reset) begin
         owed_q.delete();
         frame_raw_bytes = 0;
         frame_overrun   = 1'b0;
         bytes_owed      = '0;
         in_long_run     = 1'b0;
         zero_owed       = 1'b0;
         frame_decoded   = 0;
         frame_too_long  = 1'b0;
         bad_frame_tally = '0;
      end else begin
         if (req_valid && !req_stall)
            decode_link_byte(req_link_byte);
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $error("result with none owed: out_byte %0d end_of_frame %0d",
                      rsp_out_byte, rsp_end_of_frame);
               mismatch_count++;
            end else begin
               want = owed_q.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
               check_field("end_of_frame", 32'(want.end_of_frame),
                           32'(rsp_end_of_frame));
               check_field("frame_status", 32'(want.frame_status),
                           32'(rsp_frame_status));
               check_field("frame_length", 32'(want.frame_length),
                           32'(rsp_frame_length));
               check_field("bad_frame_total", want.bad_frame_total,
                           rsp_bad_frame_total);
            end
         end
      end
      results_owed <= owed_q.size();
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// COBS stream deframer testbench
// Feeds the deframer a short list of hand-picked frames, then random COBS
// frames, truncated runs, noise and empty frames, plus one maximal long-code
// frame, one of mixed runs right at raw capacity and one over raw capacity.
// Four phases vary sender gaps and receiver stalls; a monitor checks every
// result.
// ----------------------------------------------------------------------------
module tb;
   import cobs_pkg::*;

   localparam int RAW_MAX        = 256;
   localparam int DECODED_MAX    = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 60;
   localparam int SEND_IDLE[4]   = '{0, 70, 0, 22};
   localparam int STALL_RATE[4]  = '{0, 0, 70, 22};

   typedef logic [7:0] byte_q_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_link_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_frame;
   logic [1:0]  rsp_frame_status;
   logic [8:0]  rsp_frame_length;
   logic [31:0] rsp_bad_frame_total;

   int mismatch_count;
   int results_owed;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cobs_stream_deframer #(
      .RAW_MAX     (RAW_MAX),
      .DECODED_MAX (DECODED_MAX)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_link_byte       (req_link_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_bad_frame_total (rsp_bad_frame_total)
   );

   cobs_decode_monitor #(
      .RAW_MAX     (RAW_MAX),
      .DECODED_MAX (DECODED_MAX)
   ) monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_link_byte       (req_link_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_bad_frame_total (rsp_bad_frame_total),
      .mismatch_count      (mismatch_count),
      .results_owed        (results_owed)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_link_byte <= value;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_block(input byte_q_type block);
      send_byte(8'(block.size() + 1));
      foreach (block[i])
         send_byte(block[i]);
   endtask

   function automatic byte_q_type make_payload(input int len, input int zero_pct);
      byte_q_type payload;
      repeat (len)
         payload.push_back(($urandom_range(99) < zero_pct) ?
                           DELIMITER : 8'($urandom_range(1, 255)));
      return payload;
   endfunction

   task automatic send_cobs_frame(input byte_q_type payload);
      byte_q_type block;
      foreach (payload[i]) begin
         if (payload[i] == DELIMITER) begin
            send_block(block);
            block.delete();
         end else begin
            block.push_back(payload[i]);
            if (block.size() == 254) begin
               send_block(block);
               block.delete();
            end
         end
      end
      send_block(block);
      send_byte(DELIMITER);
   endtask

   task automatic send_random_frame();
      int kind;
      int code;
      kind = $urandom_range(99);
      if (kind < 50) begin
         send_cobs_frame(make_payload($urandom_range(0, 24), 25));
      end else if (kind < 60) begin
         send_cobs_frame(make_payload($urandom_range(1, 40), 0));
      end else if (kind < 75) begin
         // break off a run before its last data byte
         code = $urandom_range(2, 30);
         send_byte(8'(code));
         repeat ($urandom_range(0, code - 2))
            send_byte(8'($urandom_range(1, 255)));
         send_byte(DELIMITER);
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)));
         send_byte(DELIMITER);
      end else if (kind < 95) begin
         send_byte(DELIMITER);
      end else begin
         repeat ($urandom_range(1, 5))
            send_byte($urandom_range(1) ? LONG_CODE : 8'h01);
         send_byte(DELIMITER);
      end
   endtask

   task automatic send_long_frame(input int which);
      byte_q_type payload;
      case (which)
         0: begin
            // full long-code run, raw length right at capacity
            payload = make_payload(254, 0);
         end
         1: begin
            // mixed runs, raw length right at capacity
            payload = make_payload(255, 30);
         end
         default: begin
            payload = make_payload($urandom_range(262, 300), 30);
         end
      endcase
      send_cobs_frame(payload);
   endtask

   initial begin
      logic [7:0] directed[] = '{
         DELIMITER, 8'h01, DELIMITER,
         8'h03, 8'h11, 8'h22, 8'h02, 8'h33, DELIMITER,
         8'h02, LONG_CODE, 8'h01, 8'h01, DELIMITER,
         8'h05, 8'h80, 8'h7F, DELIMITER,
         LONG_CODE, 8'hAA, DELIMITER,
         DELIMITER, DELIMITER,
         8'h02, 8'h55, DELIMITER
      };
      int phase_start;
      bit long_sent;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_byte(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         stall_pct     = STALL_RATE[phase];
         phase_start   = sent_count;
         long_sent     = 1'b0;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            if (phase > 0 && !long_sent && sent_count - phase_start >= PHASE_ITEMS / 2) begin
               send_long_frame(phase - 1);
               long_sent = 1'b1;
            end else begin
               send_random_frame();
            end
         end
         // hold off until every owed result has come back
         req_valid <= 1'b0;
         do @(posedge clock); while (results_owed != 0);
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
